### rtl/tlmsc_pkg.sv
package tlmsc_pkg;

    localparam int COEF_W     = 16;
    localparam int VOLT_W     = 18;
    localparam int DIM_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PULSE_W    = 16;
    localparam int FRAC_BITS  = 14;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STEP   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_SELF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_NEXT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_OPP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd5;

    localparam logic signed [COEF_W-1:0] RST_COEF_SELF = -16'sd3377;
    localparam logic signed [COEF_W-1:0] RST_COEF_NEXT = 16'sd5793;
    localparam logic signed [COEF_W-1:0] RST_COEF_OPP  = 16'sd8208;
    localparam logic signed [COEF_W-1:0] RST_COEF_PREV = 16'sd5793;
    localparam logic [DIM_W-1:0]         RST_DIM       = 7'd51;

    typedef struct packed {
        logic signed [COEF_W-1:0] c_self;
        logic signed [COEF_W-1:0] c_next;
        logic signed [COEF_W-1:0] c_opp;
        logic signed [COEF_W-1:0] c_prev;
    } t_coefs;

endpackage

### rtl/tlm_mesh_scatter_connect_core.sv
// channel | direction | handshake             | payload
// item in | in        | i_valid / o_ready     | i_op, i_node_x, i_node_y, i_pulse_value
// result  | out       | o_valid / i_ready     | o_node_voltage, o_peak_voltage
// config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Load passes through S_LOAD back to idle; a read goes through S_RD_ADDR and
// S_RD_DATA, plus any wait on the result register. Step sweeps the incident
// memory one node per cycle over GRID_COLUMNS*(GRID_ROWS+1) scan slots (one flush
// row), then the pipeline drains. After reset a clearing pass over all nodes
// zeroes the stores; o_ready is low during it. Config writes are always taken.
// A waiting result does not block the next item; a read waits only for the result register.
module tlm_mesh_scatter_connect_core #(
    parameter int GRID_COLUMNS = 64,
    parameter int GRID_ROWS    = 64,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [1:0]                             i_op,
    input  logic [5:0]                             i_node_x,
    input  logic [5:0]                             i_node_y,
    input  logic signed [tlmsc_pkg::PULSE_W-1:0]   i_pulse_value,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [tlmsc_pkg::VOLT_W-1:0]    o_node_voltage,
    output logic [tlmsc_pkg::VOLT_W-1:0]           o_peak_voltage,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [tlmsc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tlmsc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import tlmsc_pkg::*;

    localparam int COLS  = GRID_COLUMNS;
    localparam int ROWS  = GRID_ROWS;
    localparam int SB    = SAMPLE_BITS;
    localparam int NODES = COLS * ROWS;
    localparam int AW    = $clog2(NODES);
    localparam int SW    = $clog2(NODES + COLS + 1);
    localparam int XW    = $clog2(COLS);
    localparam int YW    = $clog2(ROWS + 1);
    localparam int MW    = (XW > YW) ? XW : YW;
    localparam int CW    = ((MW > DIM_W) ? MW : DIM_W) + 1;
    localparam int CHAIN = 2 * COLS + 1;
    localparam int PW    = (SB > PULSE_W) ? SB : PULSE_W;
    localparam int EW    = (SB + 2 > VOLT_W) ? SB + 2 : VOLT_W;

    localparam logic signed [PW-1:0] PMAX = PW'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] PMIN = -PMAX - PW'(1);
    localparam logic signed [EW-1:0] VMAX = EW'((64'sd1 <<< (VOLT_W - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] VMIN = -VMAX - EW'(1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_STEP, S_RD_ADDR, S_RD_DATA
    } t_state;

    // ---------------- configuration
    t_coefs            r_coefs;
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.c_self <= RST_COEF_SELF;
            r_coefs.c_next <= RST_COEF_NEXT;
            r_coefs.c_opp  <= RST_COEF_OPP;
            r_coefs.c_prev <= RST_COEF_PREV;
            r_width        <= RST_DIM;
            r_height       <= RST_DIM;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COEF_SELF: r_coefs.c_self <= $signed(i_cfg_data);
                REG_COEF_NEXT: r_coefs.c_next <= $signed(i_cfg_data);
                REG_COEF_OPP:  r_coefs.c_opp  <= $signed(i_cfg_data);
                REG_COEF_PREV: r_coefs.c_prev <= $signed(i_cfg_data);
                REG_WIDTH:     r_width        <= i_cfg_data[DIM_W-1:0];
                REG_HEIGHT:    r_height       <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- control
    t_state                     r_state;
    logic [AW-1:0]              r_clr;
    logic                       r_inside;
    logic [AW-1:0]              r_addr;
    logic signed [PULSE_W-1:0]  r_pulse;
    logic                       r_out_valid;
    logic signed [VOLT_W-1:0]   r_out_volt;
    logic [VOLT_W-1:0]          r_out_peak;
    logic                       in_inside;
    logic [AW-1:0]              in_addr;
    logic                       pipe_busy;
    logic                       r_scan_done;
    logic signed [VOLT_W-1:0]   rd_volt;
    logic [VOLT_W-1:0]          rd_peak;

    assign in_inside = (32'(i_node_x) < 32'(COLS)) && (32'(i_node_y) < 32'(ROWS));
    assign in_addr   = AW'(32'(i_node_y) * 32'(COLS) + 32'(i_node_x));
    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_node_voltage = r_out_volt;
    assign o_peak_voltage = r_out_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && r_state != S_RD_DATA) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(NODES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_inside <= in_inside;
                        r_addr   <= in_addr;
                        r_pulse  <= i_pulse_value;
                        unique case (i_op)
                            OP_LOAD: r_state <= S_LOAD;
                            OP_STEP: r_state <= S_STEP;
                            OP_READ: r_state <= S_RD_ADDR;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_LOAD: r_state <= S_IDLE;
                S_STEP: begin
                    if (r_scan_done && !pipe_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RD_ADDR: r_state <= S_RD_DATA;
                S_RD_DATA: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_volt  <= r_inside ? rd_volt : '0;
                        r_out_peak  <= r_inside ? rd_peak : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------- node sweep
    logic [XW-1:0] r_sx;
    logic [YW-1:0] r_sy;
    logic [SW-1:0] r_sn;
    logic          r_p1_v, r_p2_v, r_p3_v, r_c_v, r_a_v;
    logic [XW-1:0] r_p1_x, r_p2_x, r_p3_x, r_c_x;
    logic [YW-1:0] r_p1_y, r_p2_y, r_p3_y, r_c_y;
    logic [SW-1:0] r_p1_n, r_p2_n, r_p3_n, r_c_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || r_state != S_STEP) begin
            r_sx        <= '0;
            r_sy        <= '0;
            r_sn        <= '0;
            r_scan_done <= 1'b0;
            r_p1_v      <= 1'b0;
        end else begin
            r_p1_v <= !r_scan_done;
            if (!r_scan_done) begin
                r_sn <= r_sn + SW'(1);
                if (r_sx == XW'(COLS - 1)) begin
                    r_sx <= '0;
                    // the extra row flushes the last real row through the line
                    if (r_sy == YW'(ROWS)) begin
                        r_scan_done <= 1'b1;
                    end else begin
                        r_sy <= r_sy + YW'(1);
                    end
                end else begin
                    r_sx <= r_sx + XW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_c_v  <= 1'b0;
        end else begin
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_c_v  <= r_p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_x <= r_sx;
        r_p1_y <= r_sy;
        r_p1_n <= r_sn;
        r_p2_x <= r_p1_x;
        r_p2_y <= r_p1_y;
        r_p2_n <= r_p1_n;
        r_p3_x <= r_p2_x;
        r_p3_y <= r_p2_y;
        r_p3_n <= r_p2_n;
        if (r_p3_v) begin
            r_c_x <= r_p3_x;
            r_c_y <= r_p3_y;
            r_c_n <= r_p3_n;
        end
    end

    assign pipe_busy = r_p1_v || r_p2_v || r_p3_v || r_c_v || r_a_v;

    // ---------------- stores
    logic [3:0][SB-1:0]       mem_inc  [NODES];
    logic signed [VOLT_W-1:0] mem_volt [NODES];
    logic [VOLT_W-1:0]        mem_peak [NODES];

    logic [3:0][SB-1:0]       rd_inc;
    logic [AW-1:0]            inc_raddr;
    logic [AW-1:0]            peak_raddr;
    logic [AW-1:0]            m_addr;
    logic                     inc_we;
    logic [AW-1:0]            inc_waddr;
    logic [3:0][SB-1:0]       inc_wdata;
    logic                     vp_we;
    logic [AW-1:0]            vp_waddr;
    logic signed [VOLT_W-1:0] volt_wdata;
    logic [VOLT_W-1:0]        peak_wdata;
    logic signed [PW-1:0]     pulse_e;
    logic [SB-1:0]            pulse_sat;
    logic [AW-1:0]            r_a_addr;
    logic [3:0][SB-1:0]       r_a_vi;
    logic signed [VOLT_W-1:0] r_a_volt;
    logic [VOLT_W-1:0]        r_a_abs;

    assign inc_raddr  = r_sn[AW-1:0];
    assign peak_raddr = (r_state == S_STEP) ? m_addr : r_addr;

    always_comb begin
        pulse_e = PW'(r_pulse);
        if (pulse_e > PMAX) begin
            pulse_sat = SB'(PMAX);
        end else if (pulse_e < PMIN) begin
            pulse_sat = SB'(PMIN);
        end else begin
            pulse_sat = SB'(pulse_e);
        end
    end

    always_comb begin
        inc_we    = 1'b0;
        inc_waddr = r_a_addr;
        inc_wdata = r_a_vi;
        priority if (r_state == S_CLEAR) begin
            inc_we    = 1'b1;
            inc_waddr = r_clr;
            inc_wdata = '0;
        end else if (r_state == S_LOAD) begin
            inc_we    = r_inside;
            inc_waddr = r_addr;
            inc_wdata = {pulse_sat, pulse_sat, pulse_sat, pulse_sat};
        end else if (r_a_v) begin
            inc_we = 1'b1;
        end
    end

    always_comb begin
        vp_we      = 1'b0;
        vp_waddr   = r_a_addr;
        volt_wdata = r_a_volt;
        peak_wdata = (r_a_abs > rd_peak) ? r_a_abs : rd_peak;
        priority if (r_state == S_CLEAR) begin
            vp_we      = 1'b1;
            vp_waddr   = r_clr;
            volt_wdata = '0;
            peak_wdata = '0;
        end else if (r_a_v) begin
            vp_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (inc_we) begin
            mem_inc[inc_waddr] <= inc_wdata;
        end
        rd_inc <= mem_inc[inc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (vp_we) begin
            mem_volt[vp_waddr] <= volt_wdata;
        end
        rd_volt <= mem_volt[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (vp_we) begin
            mem_peak[vp_waddr] <= peak_wdata;
        end
        rd_peak <= mem_peak[peak_raddr];
    end

    // ---------------- scatter and line of cells
    logic [3:0][SB-1:0] s_new;
    logic [3:0][SB-1:0] chain_s [CHAIN];

    tlmsc_scatter #(
        .SAMPLE_BITS (SB)
    ) u_scatter (
        .i_clk   (i_clk),
        .i_vi    (rd_inc),
        .i_coefs (r_coefs),
        .o_s     (s_new)
    );

    // chain_s[j] holds the node j places before the newest one
    for (genvar j = 0; j < CHAIN; j++) begin : g_chain
        if (j == 0) begin : g_head
            tlmsc_cell #(
                .SAMPLE_BITS (SB)
            ) u_cell (
                .i_clk   (i_clk),
                .i_shift (r_p3_v),
                .i_s     (s_new),
                .o_s     (chain_s[j])
            );
        end else begin : g_body
            tlmsc_cell #(
                .SAMPLE_BITS (SB)
            ) u_cell (
                .i_clk   (i_clk),
                .i_shift (r_p3_v),
                .i_s     (chain_s[j-1]),
                .o_s     (chain_s[j])
            );
        end
    end

    // ---------------- connect: node one row behind the newest cell
    logic [XW-1:0]            fx;
    logic [YW-1:0]            fy;
    logic                     f_use;
    logic [3:0][SB-1:0]       f_vi;
    logic signed [SB+1:0]     f_sum;
    logic signed [EW-1:0]     f_sum_e;
    logic signed [VOLT_W-1:0] f_volt;
    logic [VOLT_W-1:0]        f_abs;

    assign fx     = r_c_x;
    assign fy     = r_c_y - YW'(1);
    assign m_addr = AW'(r_c_n - SW'(COLS));

    always_comb begin
        f_use = r_c_v && (r_c_y != '0) && (CW'(fx) < CW'(r_width))
              && (CW'(fy) < CW'(r_height));
        f_vi[3] = (fx != '0) ? chain_s[COLS+1][1] : '0;
        f_vi[1] = ((CW'(fx) + CW'(1) < CW'(r_width)) && (CW'(fx) + CW'(1) < CW'(COLS)))
                ? chain_s[COLS-1][3] : '0;
        f_vi[2] = (fy != '0) ? chain_s[2*COLS][0] : '0;
        f_vi[0] = ((CW'(fy) + CW'(1) < CW'(r_height)) && (CW'(fy) + CW'(1) < CW'(ROWS)))
                ? chain_s[0][2] : '0;
        f_sum = (SB+2)'($signed(f_vi[0])) + (SB+2)'($signed(f_vi[1]))
              + (SB+2)'($signed(f_vi[2])) + (SB+2)'($signed(f_vi[3]));
        f_sum_e = EW'(f_sum);
        if (f_sum_e > VMAX) begin
            f_volt = VOLT_W'(VMAX);
        end else if (f_sum_e < VMIN) begin
            f_volt = VOLT_W'(VMIN);
        end else begin
            f_volt = VOLT_W'(f_sum_e);
        end
        f_abs = f_volt[VOLT_W-1] ? VOLT_W'(-f_volt) : VOLT_W'(f_volt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= f_use;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_addr <= m_addr;
        r_a_vi   <= f_vi;
        r_a_volt <= f_volt;
        r_a_abs  <= f_abs;
    end

    // ---------------- checks
    a_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_v && r_state == S_STEP && !r_scan_done && r_sy < YW'(ROWS))
            |-> (inc_raddr != r_a_addr))
        else $error("connect write hits the node being scattered");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_STEP) |-> !pipe_busy)
        else $error("sweep pipeline busy outside a step");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RD_DATA))
        else $error("result raised without a read");

endmodule

### rtl/tlmsc_cell.sv
module tlmsc_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic [3:0][SAMPLE_BITS-1:0] i_s,
    output logic [3:0][SAMPLE_BITS-1:0] o_s
);
    // one node's four scattered pulses, moved one place down the line per node
    logic [3:0][SAMPLE_BITS-1:0] r_s;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_s <= i_s;
        end
    end

    assign o_s = r_s;

endmodule

### rtl/tlmsc_scatter.sv
module tlmsc_scatter #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic [3:0][SAMPLE_BITS-1:0] i_vi,
    input  tlmsc_pkg::t_coefs           i_coefs,
    output logic [3:0][SAMPLE_BITS-1:0] o_s
);
    import tlmsc_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int PRODW  = SB + COEF_W;
    localparam int ACCW   = SB + COEF_W + 2;
    localparam logic signed [ACCW-1:0] HALF = ACCW'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [ACCW-1:0] SMAX = ACCW'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [ACCW-1:0] SMIN = -SMAX - ACCW'(1);

    logic signed [COEF_W-1:0] coef [4];
    logic signed [PRODW-1:0]  r_prod [4][4];
    logic signed [ACCW-1:0]   acc [4];
    logic signed [ACCW-1:0]   shr [4];
    logic [3:0][SB-1:0]       r_s;

    assign coef[0] = i_coefs.c_self;
    assign coef[1] = i_coefs.c_next;
    assign coef[2] = i_coefs.c_opp;
    assign coef[3] = i_coefs.c_prev;

    // circulant matrix: port i takes port k through coefficient (k - i) mod 4
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[i][k] <= $signed(i_vi[k]) * coef[(k - i) & 3];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            acc[i] = ACCW'(r_prod[i][0]) + ACCW'(r_prod[i][1])
                   + ACCW'(r_prod[i][2]) + ACCW'(r_prod[i][3]) + HALF;
            shr[i] = acc[i] >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            if (shr[i] > SMAX) begin
                r_s[i] <= SB'(SMAX);
            end else if (shr[i] < SMIN) begin
                r_s[i] <= SB'(SMIN);
            end else begin
                r_s[i] <= SB'(shr[i]);
            end
        end
    end

    assign o_s = r_s;

endmodule

### tb/tlmsc_checker.sv
module tlmsc_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic [1:0]                            i_op,
    input  logic [5:0]                            i_node_x,
    input  logic [5:0]                            i_node_y,
    input  logic signed [tlmsc_pkg::PULSE_W-1:0]  i_pulse_value,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic [tlmsc_pkg::VOLT_W-1:0]          i_node_voltage,
    input  logic [tlmsc_pkg::VOLT_W-1:0]          i_peak_voltage,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [tlmsc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tlmsc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                    o_errors,
    output int                                    o_pending
);
    import tlmsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS  = 64;
    localparam int ROWS  = 64;
    localparam int NODES = COLS * ROWS;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage;
        logic [VOLT_W-1:0] peak;
    } t_node_reading;

    int incident [NODES][4];
    int scattered[NODES][4];
    int node_volt[NODES];
    int node_peak[NODES];
    int coef[4];                // self, next, opposite, prev
    int span_x, span_y;
    int fail_count;
    int due_count;

    t_node_reading readings_due[$];

    function automatic int clamp_sample(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic void advance_grid();
        int w, h, n;
        longint acc, v;
        w = (span_x > COLS) ? COLS : span_x;
        h = (span_y > ROWS) ? ROWS : span_y;
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                n = y * COLS + x;
                for (int i = 0; i < 4; i++) begin
                    acc = 0;
                    for (int k = 0; k < 4; k++)
                        acc += longint'(incident[n][k]) * longint'(coef[(k - i + 4) % 4]);
                    // floor after adding half an lsb
                    scattered[n][i] = clamp_sample((acc + 8192) >>> 14);
                end
            end
        end
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                n = y * COLS + x;
                incident[n][3] = (x > 0) ? scattered[n - 1][1] : 0;
                incident[n][1] = (x + 1 < w) ? scattered[n + 1][3] : 0;
                incident[n][2] = (y > 0) ? scattered[n - COLS][0] : 0;
                incident[n][0] = (y + 1 < h) ? scattered[n + COLS][2] : 0;
                v = longint'(incident[n][0]) + incident[n][1] + incident[n][2]
                    + incident[n][3];
                if (v > 131071) v = 131071;
                if (v < -131072) v = -131072;
                node_volt[n] = int'(v);
                if ((v < 0 ? -v : v) > node_peak[n]) node_peak[n] = int'(v < 0 ? -v : v);
            end
        end
    endfunction

    assign o_errors  = fail_count;
    assign o_pending = due_count;

    always @(posedge i_clk) begin
        int n;
        t_node_reading exp_r;
        if (!i_rst_n) begin
            foreach (incident[j]) begin
                for (int i = 0; i < 4; i++) begin
                    incident[j][i]  = 0;
                    scattered[j][i] = 0;
                end
                node_volt[j] = 0;
                node_peak[j] = 0;
            end
            coef[0] = RST_COEF_SELF;
            coef[1] = RST_COEF_NEXT;
            coef[2] = RST_COEF_OPP;
            coef[3] = RST_COEF_PREV;
            span_x = RST_DIM;
            span_y = RST_DIM;
            readings_due.delete();
            fail_count = 0;
            due_count  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_COEF_SELF: coef[0] = int'($signed(i_cfg_data));
                    REG_COEF_NEXT: coef[1] = int'($signed(i_cfg_data));
                    REG_COEF_OPP:  coef[2] = int'($signed(i_cfg_data));
                    REG_COEF_PREV: coef[3] = int'($signed(i_cfg_data));
                    REG_WIDTH:     span_x = int'(i_cfg_data[DIM_W-1:0]);
                    REG_HEIGHT:    span_y = int'(i_cfg_data[DIM_W-1:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                n = int'(i_node_y) * COLS + int'(i_node_x);
                case (i_op)
                    OP_LOAD: for (int i = 0; i < 4; i++) incident[n][i] = int'(i_pulse_value);
                    OP_STEP: advance_grid();
                    OP_READ: begin
                        exp_r.voltage = node_volt[n][VOLT_W-1:0];
                        exp_r.peak    = node_peak[n][VOLT_W-1:0];
                        readings_due.push_back(exp_r);
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (readings_due.size() == 0) begin
                    $error("unexpected result: voltage %0d peak %0d",
                           $signed(i_node_voltage), i_peak_voltage);
                    fail_count++;
                end else begin
                    exp_r = readings_due.pop_front();
                    if (exp_r.voltage !== i_node_voltage) begin
                        $error("node_voltage: expected %0d, got %0d",
                               $signed(exp_r.voltage), $signed(i_node_voltage));
                        fail_count++;
                    end
                    if (exp_r.peak !== i_peak_voltage) begin
                        $error("peak_voltage: expected %0d, got %0d",
                               exp_r.peak, i_peak_voltage);
                        fail_count++;
                    end
                end
            end
            due_count = readings_due.size();
        end
    end

endmodule

### tb/tb.sv
module tb;
    import tlmsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [1:0]                i_op;
    logic [5:0]                i_node_x;
    logic [5:0]                i_node_y;
    logic signed [PULSE_W-1:0] i_pulse_value;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [VOLT_W-1:0]  o_node_voltage;
    logic [VOLT_W-1:0]         o_peak_voltage;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    int errors, pending;
    int reads_sent;
    bit calm;           // no idling on the input side while set
    bit long_hold_done;

    tlm_mesh_scatter_connect_core DUT (.*);

    tlmsc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_op(i_op), .i_node_x(i_node_x), .i_node_y(i_node_y),
        .i_pulse_value(i_pulse_value),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_node_voltage(o_node_voltage), .i_peak_voltage(o_peak_voltage),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("[tlm_mesh_scatter_connect_core] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver side: random back-pressure, one long hold once reads are flowing
    initial begin
        int n;
        i_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!long_hold_done && reads_sent >= 25) begin
                long_hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            n = pick_gap();
            if (n > 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    task automatic push_item(logic [1:0] op, logic [5:0] x, logic [5:0] y,
                             logic [15:0] p);
        int n;
        i_valid       <= 1'b1;
        i_op          <= op;
        i_node_x      <= x;
        i_node_y      <= y;
        i_pulse_value <= p;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (op == OP_READ) reads_sent++;
        n = calm ? 0 : pick_gap();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // wait for all readings, then for any step still sweeping
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(logic [15:0] cs, logic [15:0] cn, logic [15:0] co,
                            logic [15:0] cp, logic [15:0] w, logic [15:0] h);
        drain();
        write_reg(REG_COEF_SELF, cs);
        write_reg(REG_COEF_NEXT, cn);
        write_reg(REG_COEF_OPP, co);
        write_reg(REG_COEF_PREV, cp);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    task automatic random_items(int count, int w, int h);
        int r, xs, ys;
        logic [1:0] op;
        xs = (w > 64) ? 64 : w;
        ys = (h > 64) ? 64 : h;
        for (int i = 0; i < count; i++) begin
            if (i % 8 == 0) calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            op = (r < 30) ? OP_LOAD : (r < 40) ? OP_STEP : (r < 95) ? OP_READ : OP_UNUSED;
            if (xs > 0 && ys > 0 && $urandom_range(0, 9) < 7)
                push_item(op, 6'($urandom_range(0, xs - 1)), 6'($urandom_range(0, ys - 1)),
                          16'($urandom));
            else
                push_item(op, 6'($urandom), 6'($urandom), 16'($urandom));
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_op          <= OP_LOAD;
        i_node_x      <= '0;
        i_node_y      <= '0;
        i_pulse_value <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_COEF_SELF;
        i_cfg_data    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: extremes, unused op, corners, outside the area in use
        push_item(OP_READ, 6'd0, 6'd0, 16'h0000);
        push_item(OP_LOAD, 6'd0, 6'd0, 16'h7fff);
        push_item(OP_LOAD, 6'd1, 6'd0, 16'h8000);
        push_item(OP_LOAD, 6'd63, 6'd63, 16'h8000);
        push_item(OP_LOAD, 6'd55, 6'd2, 16'h1234);
        push_item(OP_UNUSED, 6'd0, 6'd0, 16'hffff);
        push_item(OP_READ, 6'd63, 6'd63, 16'h0000);
        push_item(OP_STEP, 6'd0, 6'd0, 16'h0000);
        push_item(OP_READ, 6'd0, 6'd0, 16'h0000);
        push_item(OP_READ, 6'd1, 6'd1, 16'hffff);
        push_item(OP_READ, 6'd55, 6'd2, 16'h0000);
        push_item(OP_READ, 6'd50, 6'd50, 16'h0000);
        push_item(OP_STEP, 6'd63, 6'd63, 16'hffff);
        push_item(OP_READ, 6'd0, 6'd1, 16'h0000);
        push_item(OP_READ, 6'd2, 6'd0, 16'h0000);
        push_item(OP_READ, 6'd63, 6'd63, 16'h0000);

        set_grid(16'hf2cf, 16'd5793, 16'd8208, 16'd5793, 16'd6, 16'd5);
        random_items(25, 6, 5);
        set_grid(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'd64, 16'd64);
        random_items(20, 64, 64);
        set_grid(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd0);
        random_items(12, 0, 0);
        set_grid(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'd127, 16'd1);
        random_items(18, 64, 1);
        set_grid(16'd8192, 16'd0, 16'h2000, 16'd0, 16'd1, 16'd127);
        random_items(18, 1, 64);
        set_grid(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'd8, 16'd8);
        random_items(30, 8, 8);

        drain();
        if (errors == 0 && pending == 0) begin
            $display("[tlm_mesh_scatter_connect_core] OK");
        end else begin
            $display("[tlm_mesh_scatter_connect_core] ERROR");
        end
        $finish;
    end

endmodule
